/* src/dual_led_dimmer_panel_control_assert.svh */
// Assertion macros shared by the checker of the dimmer panel controller.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DUAL_LED_DIMMER_PANEL_CONTROL_ASSERT_SVH
`define DUAL_LED_DIMMER_PANEL_CONTROL_ASSERT_SVH

// Same-cycle implication.
`define DLDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dldp assertion failed");

// Next-cycle implication.
`define DLDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dldp assertion failed");

`endif

/* src/dldp_pkg.sv */
// Shared types, constants and the ramp function of the dimmer panel controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package dldp_pkg;

  localparam int DutyBits  = 8;
  localparam int TimerBits = 16;
  localparam int CfgIdxBits = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_KEY    = 2'd1,
    OP_SENSOR = 2'd2
  } opcode_e;

  // Register indexes on the configuration port
  localparam logic [CfgIdxBits-1:0] RegStepSize    = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegMaxLevel    = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegMinLevel    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegLockout     = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegRampPeriod  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegStartLevel  = 3'd5;

  // Reset values of the configuration registers
  localparam logic [DutyBits-1:0]  StepSizeRst   = DutyBits'(25);
  localparam logic [DutyBits-1:0]  MaxLevelRst   = DutyBits'(250);
  localparam logic [DutyBits-1:0]  MinLevelRst   = DutyBits'(100);
  localparam logic [TimerBits-1:0] LockoutRst    = TimerBits'(500);
  localparam logic [DutyBits-1:0]  RampPeriodRst = DutyBits'(5);
  localparam logic [DutyBits-1:0]  StartLevelRst = '0;

  // Per-sensor control for one accepted transaction
  typedef struct packed {
    logic tick;
    logic mark;
  } sns_ctrl_t;

  // One ramp step of a channel duty toward the setpoint, or to zero when the channel is off
  function automatic logic [DutyBits-1:0] ramp_step(input logic [DutyBits-1:0] duty,
                                                   input logic [DutyBits-1:0] target,
                                                   input logic on);
    logic [DutyBits-1:0] res;
    res = duty;
    if (!on) begin
      res = '0;
    end else if (duty < target && duty != '1) begin
      res = duty + DutyBits'(1);
    end else if (duty > target) begin
      res = duty - DutyBits'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/dldp_sensor.sv */
// One magnet sensor: pending flag and saturating lockout timer.
// Depends on dldp_pkg.
`default_nettype none

module dldp_sensor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dldp_pkg::sns_ctrl_t             ctrl_i,
  input  logic [dldp_pkg::TimerBits-1:0]  lockout_i,
  output logic                            fire_o
);
  import dldp_pkg::*;

  logic                 pending_q, pending_d;
  logic [TimerBits-1:0] elapsed_q, elapsed_d;
  logic [TimerBits-1:0] elapsed_inc;

  // saturate at the top of the timer
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TimerBits'(1);
  assign fire_o = ctrl_i.tick && pending_q && (elapsed_inc > lockout_i);

  always_comb begin
    pending_d = pending_q;
    elapsed_d = elapsed_q;
    if (ctrl_i.tick) begin
      elapsed_d = fire_o ? '0 : elapsed_inc;
      if (fire_o) pending_d = 1'b0;
    end else if (ctrl_i.mark) begin
      pending_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      elapsed_q <= '0;
    end else begin
      pending_q <= pending_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire

/* src/dual_led_dimmer_panel_control.sv */
// Dual LED dimmer panel controller: one transaction in, one result out, each cycle
// unless stalled. Depends on dldp_pkg and dldp_sensor.
//
// Every accepted transaction (tick, key snapshot or magnet event) updates the state
// in the cycle it is accepted and its result appears on the output register in the
// next cycle, so the block sustains one transaction per clock unless in_stall_o is
// raised (only while a result sits in the output register and out_stall_i holds it). The
// setpoint and saved level reset to the reset value of start_level (zero); a value
// written to start_level has no effect, since every reset reloads the default.
// Configuration writes are always ready and apply on the next clock.
`default_nettype none

module dual_led_dimmer_panel_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dldp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [dldp_pkg::TimerBits-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic                              key_up_i,
  input  logic                              key_down_i,
  input  logic                              key_toggle_left_i,
  input  logic                              key_toggle_right_i,
  input  logic                              sensor_select_i,
  input  logic                              left_magnet_level_i,
  input  logic                              right_magnet_level_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dldp_pkg::DutyBits-1:0]     right_duty_o,
  output logic [dldp_pkg::DutyBits-1:0]     left_duty_o,
  output logic                              right_enabled_o,
  output logic                              left_enabled_o,
  output logic [dldp_pkg::DutyBits-1:0]     level_setpoint_o,
  output logic                              save_request_o
);
  import dldp_pkg::*;

  // configuration registers
  logic [DutyBits-1:0]  step_q, max_q, min_q, period_q;
  logic [TimerBits-1:0] lockout_q;

  // block state
  logic [DutyBits-1:0]  setpoint_q, setpoint_d;
  logic [DutyBits-1:0]  saved_q, saved_d;
  logic [DutyBits-1:0]  right_lvl_q, right_lvl_d;
  logic [DutyBits-1:0]  left_lvl_q, left_lvl_d;
  logic                 right_on_q, right_on_d;
  logic                 left_on_q, left_on_d;
  logic [DutyBits-1:0]  ramp_cnt_q, ramp_cnt_d;
  logic                 save_d;

  // output register
  logic                 out_valid_q;
  logic [DutyBits-1:0]  right_duty_q, left_duty_q, setpoint_out_q;
  logic                 right_en_q, left_en_q, save_q;

  logic                 accept;
  opcode_e              op;
  sns_ctrl_t            left_ctrl, right_ctrl;
  logic                 left_fire, right_fire;

  logic [DutyBits:0]    up_sum, dn_limit;
  logic [DutyBits-1:0]  sp_up;
  logic [DutyBits-1:0]  cnt_inc, period;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StepSizeRst;
      max_q     <= MaxLevelRst;
      min_q     <= MinLevelRst;
      lockout_q <= LockoutRst;
      period_q  <= RampPeriodRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStepSize:   step_q    <= cfg_data_i[DutyBits-1:0];
        RegMaxLevel:   max_q     <= cfg_data_i[DutyBits-1:0];
        RegMinLevel:   min_q     <= cfg_data_i[DutyBits-1:0];
        RegLockout:    lockout_q <= cfg_data_i;
        RegRampPeriod: period_q  <= cfg_data_i[DutyBits-1:0];
        // start_level only matters at reset, which restores its default
        RegStartLevel: ;
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign op         = opcode_e'(opcode_i);

  assign left_ctrl.tick  = accept && (op == OP_TICK);
  assign left_ctrl.mark  = accept && (op == OP_SENSOR) && !sensor_select_i;
  assign right_ctrl.tick = accept && (op == OP_TICK);
  assign right_ctrl.mark = accept && (op == OP_SENSOR) && sensor_select_i;

  dldp_sensor u_left_sensor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (left_ctrl),
    .lockout_i (lockout_q),
    .fire_o    (left_fire)
  );

  dldp_sensor u_right_sensor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (right_ctrl),
    .lockout_i (lockout_q),
    .fire_o    (right_fire)
  );

  // key arithmetic: up first, then down
  assign up_sum   = {1'b0, setpoint_q} + {1'b0, step_q};
  assign dn_limit = {1'b0, min_q} + {1'b0, step_q};
  assign sp_up    = !key_up_i ? setpoint_q
                  : (up_sum > {1'b0, max_q}) ? max_q : up_sum[DutyBits-1:0];

  // a zero period steps on every tick
  assign cnt_inc = ramp_cnt_q + DutyBits'(1);
  assign period  = (period_q == '0) ? DutyBits'(1) : period_q;

  always_comb begin
    setpoint_d  = setpoint_q;
    saved_d     = saved_q;
    right_lvl_d = right_lvl_q;
    left_lvl_d  = left_lvl_q;
    right_on_d  = right_on_q;
    left_on_d   = left_on_q;
    ramp_cnt_d  = ramp_cnt_q;
    save_d      = 1'b0;
    if (accept) begin
      case (op)
        OP_TICK: begin
          if (left_fire)  left_on_d  = !left_magnet_level_i;
          if (right_fire) right_on_d = !right_magnet_level_i;
          ramp_cnt_d = cnt_inc;
          if (cnt_inc >= period) begin
            ramp_cnt_d  = '0;
            right_lvl_d = ramp_step(right_lvl_q, setpoint_q, right_on_d);
            left_lvl_d  = ramp_step(left_lvl_q, setpoint_q, left_on_d);
          end
        end
        OP_KEY: begin
          setpoint_d = sp_up;
          if (key_down_i) begin
            setpoint_d = ({1'b0, sp_up} < dn_limit) ? min_q : sp_up - step_q;
          end
          if (key_toggle_left_i)  left_on_d  = !left_on_q;
          if (key_toggle_right_i) right_on_d = !right_on_q;
          if (setpoint_d != saved_q) begin
            saved_d = setpoint_d;
            save_d  = 1'b1;
          end
        end
        OP_SENSOR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= StartLevelRst;
      saved_q     <= StartLevelRst;
      right_lvl_q <= '0;
      left_lvl_q  <= '0;
      right_on_q  <= 1'b0;
      left_on_q   <= 1'b0;
      ramp_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      setpoint_q  <= setpoint_d;
      saved_q     <= saved_d;
      right_lvl_q <= right_lvl_d;
      left_lvl_q  <= left_lvl_d;
      right_on_q  <= right_on_d;
      left_on_q   <= left_on_d;
      ramp_cnt_q  <= ramp_cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // load the result of each accepted transaction, hold it otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      right_duty_q   <= right_lvl_d;
      left_duty_q    <= left_lvl_d;
      right_en_q     <= right_on_d;
      left_en_q      <= left_on_d;
      setpoint_out_q <= setpoint_d;
      save_q         <= save_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign right_duty_o     = right_duty_q;
  assign left_duty_o      = left_duty_q;
  assign right_enabled_o  = right_en_q;
  assign left_enabled_o   = left_en_q;
  assign level_setpoint_o = setpoint_out_q;
  assign save_request_o   = save_q;

endmodule

`default_nettype wire

/* src/dldp_checker.sv */
// Port-level checker of the dimmer panel controller, bound to the top level.
// Depends on dldp_pkg and dual_led_dimmer_panel_control_assert.svh.
`default_nettype none

`include "dual_led_dimmer_panel_control_assert.svh"

module dldp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [dldp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [dldp_pkg::TimerBits-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic                              key_up_i,
  input  logic                              key_down_i,
  input  logic                              key_toggle_left_i,
  input  logic                              key_toggle_right_i,
  input  logic                              sensor_select_i,
  input  logic                              left_magnet_level_i,
  input  logic                              right_magnet_level_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [dldp_pkg::DutyBits-1:0]     right_duty_o,
  input  logic [dldp_pkg::DutyBits-1:0]     left_duty_o,
  input  logic                              right_enabled_o,
  input  logic                              left_enabled_o,
  input  logic [dldp_pkg::DutyBits-1:0]     level_setpoint_o,
  input  logic                              save_request_o
);
  import dldp_pkg::*;

  // an accepted transaction always produces a result in the next cycle
  `DLDP_ASSERT_NEXT(a_accept_gives_result, in_valid_i && !in_stall_o, out_valid_o)

  // input backs up only behind a held result
  `DLDP_ASSERT_NOW(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i)

  // a stalled result stays valid
  `DLDP_ASSERT_NEXT(a_out_valid_holds, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result does not change
  `DLDP_ASSERT_NEXT(a_out_payload_holds, out_valid_o && out_stall_i,
    $stable(level_setpoint_o) && $stable(right_duty_o) && $stable(left_duty_o))

endmodule

bind dual_led_dimmer_panel_control dldp_checker u_dldp_checker (.*);

`default_nettype wire
